[rtl/bfaq_pkg.sv]
// ----------------------------------------------------------------------------
// bfaq_pkg
// Shared constants and types for the Bloom filter add/query block.
// ----------------------------------------------------------------------------
package bfaq_pkg;

  localparam int unsigned MaxFilterBits = 65536;
  localparam int unsigned MaxHashes     = 32;
  localparam int unsigned PosW          = $clog2(MaxFilterBits);
  localparam int unsigned StoreWords    = MaxFilterBits / 8;
  localparam int unsigned AddrW         = $clog2(StoreWords);
  localparam int unsigned BitCntW       = 17;
  localparam int unsigned HashCntW      = 6;

  localparam logic [31:0] FnvBasis = 32'h811c9dc5;
  localparam logic [31:0] FnvPrime = 32'h01000193;

  localparam logic [0:0] CfgBitCount  = 1'b0;
  localparam logic [0:0] CfgHashCount = 1'b1;

  localparam logic OpAdd   = 1'b0;
  localparam logic OpQuery = 1'b1;

  // Request to the modulo unit and its answer.
  typedef struct packed {
    logic        start;
    logic [31:0] dividend;
    logic [16:0] divisor;
  } bfaq_mod_req_t;

  typedef struct packed {
    logic            done;
    logic [PosW-1:0] rem;
  } bfaq_mod_rsp_t;

endpackage

[rtl/bloom_filter_add_query.sv]
// ----------------------------------------------------------------------------
// bloom_filter_add_query
// Bloom filter with add and query, double hashing with FNV-1a and djb2 variants (sign-extended bytes, djb2 seed zero).
// ----------------------------------------------------------------------------
// Key bytes arrive one item at a time, with tuser carrying the operation
// (add or query) and tlast marking the final byte. A byte that is not last
// is accepted in StIdle, folded into the djb2 hash with the FNV xor formed in
// StFold, and put through the registered FNV multiply in StMul before the
// next byte can be taken. On the last byte the block forms each probe position
// h1 + i*h2 in turn, reduces it modulo the bit count in a shared bit-serial
// remainder unit, and reads and, for an add, rewrites one byte of the filter
// memory, stepping through StProbe, StMod, StRead and StCheck for each probe.
// It then offers the result item of the key, and takes no new item until that
// result has been accepted. After reset the block clears all 8192 filter
// memory bytes, one byte a cycle, and accepts no item meanwhile.
// Configuration is written through cfg_we, cfg_addr and cfg_wdata; the user
// must write it only while the block is idle, as the block does not enforce it.
// ----------------------------------------------------------------------------
module bloom_filter_add_query
  import bfaq_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] key_byte
  input  logic        in_tuser,   // [0] op
  input  logic        in_tlast,   // last_byte
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // [0] hit, [7:1] zero
  input  logic        cfg_we,
  input  logic        cfg_addr,
  input  logic [16:0] cfg_wdata
);

  localparam logic [3:0] StClear = 4'd0;
  localparam logic [3:0] StIdle  = 4'd1;
  localparam logic [3:0] StFold  = 4'd2;
  localparam logic [3:0] StMul   = 4'd3;
  localparam logic [3:0] StProbe = 4'd4;
  localparam logic [3:0] StMod   = 4'd5;
  localparam logic [3:0] StRead  = 4'd6;
  localparam logic [3:0] StCheck = 4'd7;
  localparam logic [3:0] StOut   = 4'd8;

  logic [3:0]  state_r, state_nxt;
  logic [16:0] bit_count_r;
  logic [5:0]  hash_count_r;
  logic [31:0] fnv_r, fnv_nxt;
  logic [31:0] djb_r, djb_nxt;
  logic [31:0] xored_r;
  logic [31:0] probe_r, probe_nxt;
  logic [5:0]  idx_r, idx_nxt;
  logic [5:0]  k_r;
  logic [16:0] n_r;
  logic        op_r, last_r, all_r, all_nxt;
  logic [7:0]  byte_r;
  logic [AddrW-1:0] clr_r, clr_nxt;
  logic [PosW-1:0]  pos_r;
  logic        hit_r;

  logic [31:0] sx;
  logic [31:0] mul_prod;

  bfaq_mod_req_t mreq;
  bfaq_mod_rsp_t mrsp;

  logic             ram_we;
  logic [AddrW-1:0] ram_addr;
  logic [7:0]       ram_wdata, ram_rdata;
  logic [7:0]       mask;

  assign sx       = {{24{byte_r[7]}}, byte_r};
  assign mul_prod = xored_r * FnvPrime;
  assign mask     = 8'd1 << pos_r[2:0];

  bfaq_mod u_mod (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (mreq),
    .rsp   (mrsp)
  );

  bfaq_ram #(.Width(8), .Depth(StoreWords)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  always_comb begin
    mreq.start    = (state_r == StProbe);
    mreq.dividend = probe_r;
    mreq.divisor  = n_r;
    ram_we    = 1'b0;
    ram_addr  = pos_r[PosW-1:3];
    ram_wdata = ram_rdata | mask;
    if (state_r == StClear) begin
      ram_we    = 1'b1;
      ram_addr  = clr_r;
      ram_wdata = '0;
    end else if (state_r == StCheck && op_r == OpAdd) begin
      ram_we = 1'b1;
    end
  end

  always_comb begin
    state_nxt = state_r;
    fnv_nxt   = fnv_r;
    djb_nxt   = djb_r;
    probe_nxt = probe_r;
    idx_nxt   = idx_r;
    all_nxt   = all_r;
    clr_nxt   = clr_r;
    unique case (state_r)
      StClear: begin
        clr_nxt = clr_r + 1'b1;
        if (&clr_r) state_nxt = StIdle;
      end
      StIdle: begin
        if (in_tvalid) state_nxt = StFold;
      end
      StFold: begin
        djb_nxt   = (djb_r << 5) + djb_r + sx;
        state_nxt = StMul;
      end
      StMul: begin
        fnv_nxt = mul_prod;
        if (last_r) begin
          probe_nxt = mul_prod;
          idx_nxt   = '0;
          all_nxt   = 1'b1;
          state_nxt = (k_r == 6'd0) ? StOut : StProbe;
        end else begin
          state_nxt = StIdle;
        end
      end
      StProbe: state_nxt = StMod;
      StMod: begin
        if (mrsp.done) state_nxt = StRead;
      end
      StRead: state_nxt = StCheck;
      StCheck: begin
        if ((ram_rdata & mask) == 8'd0) all_nxt = 1'b0;
        probe_nxt = probe_r + djb_r;
        idx_nxt   = idx_r + 6'd1;
        state_nxt = (idx_r + 6'd1 == k_r) ? StOut : StProbe;
      end
      StOut: begin
        if (out_tready) begin
          fnv_nxt   = FnvBasis;
          djb_nxt   = '0;
          state_nxt = StIdle;
        end
      end
      default: state_nxt = StIdle;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= StClear;
      clr_r        <= '0;
      bit_count_r  <= 17'd65536;
      hash_count_r <= 6'd4;
      fnv_r        <= FnvBasis;
      djb_r        <= '0;
    end else begin
      state_r <= state_nxt;
      clr_r   <= clr_nxt;
      fnv_r   <= fnv_nxt;
      djb_r   <= djb_nxt;
      if (cfg_we) begin
        unique case (cfg_addr)
          CfgBitCount:  bit_count_r  <= cfg_wdata;
          CfgHashCount: hash_count_r <= cfg_wdata[5:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    probe_r <= probe_nxt;
    idx_r   <= idx_nxt;
    all_r   <= all_nxt;
    if (state_r == StIdle && in_tvalid) begin
      byte_r <= in_tdata;
      last_r <= in_tlast;
      op_r   <= in_tuser;
      // Clamp both registers on every byte; only the last byte's copy is used.
      n_r    <= (bit_count_r < 17'd8) ? 17'd8 :
                (bit_count_r > 17'(MaxFilterBits)) ? 17'(MaxFilterBits) : bit_count_r;
      k_r    <= (hash_count_r > 6'(MaxHashes)) ? 6'(MaxHashes) : hash_count_r;
    end
    if (state_r == StFold) xored_r <= fnv_r ^ sx;
    if (mrsp.done) pos_r <= mrsp.rem;
    if (state_r == StMul || state_r == StCheck) hit_r <= (op_r == OpQuery) && all_nxt;
  end

  assign in_tready  = (state_r == StIdle);
  assign out_tvalid = (state_r == StOut);
  assign out_tdata  = {7'd0, hit_r};

endmodule

[rtl/bfaq_ram.sv]
// ----------------------------------------------------------------------------
// bfaq_ram
// Generic single-port RAM with registered read data.
// ----------------------------------------------------------------------------
module bfaq_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] addr,
  input  logic [Width-1:0]         wdata,
  output logic [Width-1:0]         rdata
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

[rtl/bfaq_mod.sv]
// ----------------------------------------------------------------------------
// bfaq_mod
// Restoring remainder unit: 32-bit dividend modulo a 17-bit divisor, one
// quotient bit per cycle.
// ----------------------------------------------------------------------------
module bfaq_mod
  import bfaq_pkg::*;
(
  input  logic          clk,
  input  logic          rst_n,
  input  bfaq_mod_req_t req,
  output bfaq_mod_rsp_t rsp
);

  logic [31:0] dvd_r, dvd_nxt;
  logic [17:0] rem_r, rem_nxt;
  logic [16:0] dvs_r;
  logic [5:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt;
  logic        done_r, done_nxt;
  logic [17:0] shifted;
  logic [17:0] diff;

  assign shifted = {rem_r[16:0], dvd_r[31]};
  assign diff    = shifted - {1'b0, dvs_r};

  always_comb begin
    dvd_nxt  = dvd_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (req.start) begin
      dvd_nxt  = req.dividend;
      rem_nxt  = '0;
      cnt_nxt  = 6'd32;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      dvd_nxt = {dvd_r[30:0], 1'b0};
      rem_nxt = diff[17] ? shifted : diff;
      cnt_nxt = cnt_r - 6'd1;
      if (cnt_r == 6'd1) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dvd_r <= dvd_nxt;
    rem_r <= rem_nxt;
    if (req.start) begin
      dvs_r <= req.divisor;
    end
  end

  assign rsp.done = done_r;
  assign rsp.rem  = rem_r[PosW-1:0];

endmodule

[bench/bfaq_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfaq_checker
// Predicts the hit flag of every key and compares it with the result items.
// ----------------------------------------------------------------------------
module bfaq_checker
  import bfaq_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [7:0]  in_tdata,
  input  logic        in_tuser,
  input  logic        in_tlast,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [7:0]  out_tdata,
  input  logic        cfg_we,
  input  logic        cfg_addr,
  input  logic [16:0] cfg_wdata,
  output int          fail_count,
  output int          pending_hits
);

  logic [16:0] bit_count;
  logic [5:0]  hash_count;
  logic [31:0] fnv_hash;
  logic [31:0] djb_hash;
  bit          filter_map [MaxFilterBits];
  logic [7:0]  hit_queue [$];

  // Folds one byte into both hashes and, on the last byte, probes the filter.
  task automatic absorb_byte(input logic op, input logic [7:0] kb, input logic last);
    logic [31:0] sx;
    logic [31:0] n;
    logic [31:0] k;
    logic [31:0] pos;
    logic        all_set;
    sx = {{24{kb[7]}}, kb};
    fnv_hash = (fnv_hash ^ sx) * FnvPrime;
    djb_hash = djb_hash * 33 + sx;
    if (last) begin
      n = bit_count;
      if (n < 8) n = 8;
      if (n > MaxFilterBits) n = MaxFilterBits;
      k = hash_count;
      if (k > MaxHashes) k = MaxHashes;
      all_set = 1'b1;
      for (int unsigned i = 0; i < k; i++) begin
        pos = (fnv_hash + i * djb_hash) % n;
        if (op == OpAdd) filter_map[pos] = 1'b1;
        else if (!filter_map[pos]) all_set = 1'b0;
      end
      hit_queue.push_back({7'd0, (op == OpQuery) && all_set});
      fnv_hash = FnvBasis;
      djb_hash = 32'd0;
    end
  endtask

  always @(posedge clk) begin
    logic [7:0] want;
    if (!rst_n) begin
      bit_count  <= 17'd65536;
      hash_count <= 6'd4;
      fnv_hash   = FnvBasis;
      djb_hash   = 32'd0;
      for (int i = 0; i < MaxFilterBits; i++) filter_map[i] = 1'b0;
      hit_queue.delete();
      fail_count   <= 0;
      pending_hits <= 0;
    end else begin
      if (cfg_we) begin
        if (cfg_addr == CfgBitCount) bit_count <= cfg_wdata;
        else hash_count <= cfg_wdata[5:0];
      end
      if (in_tvalid && in_tready) absorb_byte(in_tuser, in_tdata, in_tlast);
      if (out_tvalid && out_tready) begin
        if (hit_queue.size() == 0) begin
          if (fail_count < 10) $display("ERROR: unexpected result %h", out_tdata);
          fail_count <= fail_count + 1;
        end else begin
          want = hit_queue.pop_front();
          if (want !== out_tdata) begin
            if (fail_count < 10)
              $display("ERROR: hit expected %h got %h", want, out_tdata);
            fail_count <= fail_count + 1;
          end
        end
      end
      pending_hits <= hit_queue.size();
    end
  end

endmodule

[bench/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Random add and query traffic against the Bloom filter block.
// ----------------------------------------------------------------------------
// Keys are sent as byte items in bursts with random gaps, while the result
// side stalls on its own pattern. Each phase sets a bit count and a hash
// count, adds some keys and queries both known and fresh keys, so that hits
// and misses both occur. A checker beside the block predicts every result.
// ----------------------------------------------------------------------------
module tb_top;
  import bfaq_pkg::*;

  localparam int WatchdogLimit = 200000;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [7:0]  in_tdata;    // [7:0] key_byte
  logic        in_tuser;    // [0] op
  logic        in_tlast;
  logic        out_tvalid;
  logic        out_tready;
  logic [7:0]  out_tdata;   // [0] hit, [7:1] zero
  logic        cfg_we;
  logic        cfg_addr;
  logic [16:0] cfg_wdata;
  int          fail_count;
  int          pending_hits;
  int          idle_cycles;
  bit          hold_off;
  bit          done_stim;

  // Keys added in the current phase, kept for later queries.
  logic [7:0] key_bytes [$];
  int         key_start [$];
  int         key_len [$];

  bloom_filter_add_query u_dut (.*);

  bfaq_checker u_check (.*);

  initial clk = 1'b0;
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Sends one byte, honouring the burst pattern, and waits for acceptance.
  // Valid stays high after acceptance; a gap or a drain lowers it.
  task automatic send_byte(input logic op, input logic [7:0] kb, input logic last);
    if ($urandom_range(0, 5) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= kb;
    in_tuser  <= op;
    in_tlast  <= last;
    do @(posedge clk); while (!in_tready);
  endtask

  // Sends a whole key; earlier bytes carry a random op, which must be ignored.
  task automatic send_key(input logic op, input int first, input int len);
    for (int i = 0; i < len; i++)
      send_byte(i == len - 1 ? op : logic'($urandom_range(0, 1)),
                key_bytes[first + i], i == len - 1);
  endtask

  task automatic send_fresh(input logic op);
    int len;
    len = $urandom_range(0, 9) == 0 ? $urandom_range(8, 12) : $urandom_range(1, 4);
    key_start.push_back(key_bytes.size());
    key_len.push_back(len);
    for (int i = 0; i < len; i++) key_bytes.push_back(8'($urandom));
    send_key(op, key_start[$], len);
  endtask

  // Waits for all results, then for the slowest key to finish.
  task automatic drain;
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_hits != 0) @(posedge clk);
    repeat (1300) @(posedge clk);
  endtask

  task automatic write_cfg(input logic addr, input logic [16:0] val);
    cfg_we    <= 1'b1;
    cfg_addr  <= addr;
    cfg_wdata <= val;
    @(posedge clk);
  endtask

  task automatic run_phase(input logic [16:0] bits, input logic [5:0] hashes, input int keys);
    int pick;
    drain;
    write_cfg(CfgBitCount, bits);
    write_cfg(CfgHashCount, hashes);
    cfg_we <= 1'b0;
    key_bytes.delete();
    key_start.delete();
    key_len.delete();
    for (int j = 0; j < keys; j++) begin
      if (key_len.size() == 0 || $urandom_range(0, 2) == 0) begin
        send_fresh(OpAdd);
      end else if ($urandom_range(0, 1) == 0) begin
        pick = $urandom_range(0, key_len.size() - 1);
        send_key(OpQuery, key_start[pick], key_len[pick]);
      end else begin
        send_fresh(OpQuery);
        key_start.pop_back();
        key_len.pop_back();
      end
    end
  endtask

  // Result side stalls on its own pattern, or holds off entirely when asked.
  always @(posedge clk) begin
    if (!rst_n) out_tready <= 1'b0;
    else if (hold_off) out_tready <= 1'b0;
    else out_tready <= ($urandom_range(0, 3) != 0);
  end

  // Watchdog on cycles without any handshake.
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) || hold_off)
      idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WatchdogLimit) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata  <= 8'd0;
    in_tuser  <= 1'b0;
    in_tlast  <= 1'b0;
    cfg_we    <= 1'b0;
    cfg_addr  <= CfgBitCount;
    cfg_wdata <= 17'd0;
    hold_off  = 1'b0;
    done_stim = 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Directed start at the reset settings: extreme bytes, an add, queries.
    key_bytes = '{8'h00, 8'hff, 8'h80, 8'h7f, 8'h01};
    key_start = '{0};
    key_len   = '{5};
    send_key(OpQuery, 0, 5);
    send_key(OpAdd, 0, 5);
    send_key(OpQuery, 0, 5);
    send_key(OpQuery, 0, 1);

    // Hash count zero and the bit count clamps, both ends.
    run_phase(17'd0, 6'd0, 4);
    run_phase(17'd3, 6'd32, 6);
    run_phase(17'h1ffff, 6'd63, 4);
    run_phase(17'd13, 6'd40, 6);

    // Long hold-off on the result side while keys keep coming.
    fork
      begin
        hold_off = 1'b1;
        repeat (3000) @(posedge clk);
        hold_off = 1'b0;
      end
      run_phase(17'd64, 6'd1, 8);
    join

    // Random phases, mostly small hash counts to keep the run short.
    for (int p = 0; p < 8; p++)
      run_phase(17'($urandom_range(8, 4096)), 6'($urandom_range(1, 6)), 40);
    run_phase(17'd65536, 6'd2, 40);
    run_phase(17'd8, 6'd3, 30);

    drain;
    if (fail_count == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end

endmodule
